// ----- src/spiee_pkg.sv -----
package spiee_pkg;

  // Default page size in bytes (power of two, 8 to 256)
  localparam int PAGE_BYTES_DEF = 32;

  localparam int MAX_WORDS = 5;

  localparam logic [1:0] CMD_START_WR = 2'd0;
  localparam logic [1:0] CMD_WR_DATA  = 2'd1;
  localparam logic [1:0] CMD_START_RD = 2'd2;
  localparam logic [1:0] CMD_RD_SLOT  = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] REG_WE_OPCODE = 2'd0;
  localparam logic [1:0] REG_WR_OPCODE = 2'd1;
  localparam logic [1:0] REG_RD_OPCODE = 2'd2;

  localparam logic [7:0] WE_OPCODE_RST = 8'h06;
  localparam logic [7:0] WR_OPCODE_RST = 8'h02;
  localparam logic [7:0] RD_OPCODE_RST = 8'h03;
  localparam logic [7:0] DUMMY_BYTE    = 8'hFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic [7:0]  bus_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       select_before;
    logic       release_after;
    logic       wait_after;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last;
  } out_word_t;

  function automatic out_word_t mk_word(input logic [7:0] b, input logic sel,
                                        input logic rel, input logic wt,
                                        input logic [7:0] rd, input logic rv);
    out_word_t w;
    w.spi_byte      = b;
    w.select_before = sel;
    w.release_after = rel;
    w.wait_after    = wt;
    w.read_data     = rd;
    w.read_valid    = rv;
    w.last          = 1'b0;
    return w;
  endfunction

endpackage

// ----- src/spi_eeprom_page_write_sequencer.sv -----
// The first output word of a request shows in the cycle after the request is taken.
// A request makes n output words (0 to 5) and holds the output queue until its last word
// leaves; the next request is taken in the cycle that word leaves, so data and read-slot
// words stream at one per cycle while out_ready stays high.
// Reset (rst_n low, synchronous): idle mode, empty output queue, opcodes 0x06/0x02/0x03.
module spi_eeprom_page_write_sequencer #(
  parameter int PAGE_BYTES = spiee_pkg::PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spiee_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spiee_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import spiee_pkg::*;

  // PAGE_BYTES must be a power of two; page offset is the low address bits
  localparam int LG  = $clog2(PAGE_BYTES);
  localparam int CLW = $clog2(PAGE_BYTES + 1);

  // Opcode registers
  logic [7:0] we_op_r, wr_op_r, rd_op_r;

  // Sequencer state
  logic [1:0]     mode_r, mode_nxt;
  logic [15:0]    addr_r, addr_nxt;
  logic [15:0]    rem_r, rem_nxt;
  logic [CLW-1:0] left_r, left_nxt;

  // Output queue: up to five words, head at entry 0
  out_word_t ent_r [MAX_WORDS];
  out_word_t ent_nxt [MAX_WORDS];
  out_word_t res [MAX_WORDS];
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] n;

  // Chunk opening
  logic           open, open_at;
  logic [15:0]    src_addr, src_rem;
  logic [CLW-1:0] room, chunk;

  logic in_fire, out_fire;

  assign cfg_ready = 1'b1;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = ent_r[0];
  // Take a new word when the queue is empty or its final word leaves now
  assign in_ready  = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      we_op_r <= WE_OPCODE_RST;
      wr_op_r <= WR_OPCODE_RST;
      rd_op_r <= RD_OPCODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WE_OPCODE: we_op_r <= cfg_data;
        REG_WR_OPCODE: wr_op_r <= cfg_data;
        REG_RD_OPCODE: rd_op_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode and next state
  always_comb begin
    mode_nxt = mode_r;
    addr_nxt = addr_r;
    rem_nxt  = rem_r;
    left_nxt = left_r;
    for (int i = 0; i < MAX_WORDS; i++) res[i] = '0;
    n        = 3'd0;
    open     = 1'b0;
    open_at  = 1'b0;
    src_addr = addr_r;
    src_rem  = rem_r;

    case (in_data.command)
      CMD_START_WR: begin
        if (mode_r == MODE_IDLE && in_data.length != 16'd0) begin
          src_addr = in_data.address;
          src_rem  = in_data.length;
          mode_nxt = MODE_WRITE;
          open     = 1'b1;
        end
      end
      CMD_WR_DATA: begin
        if (mode_r == MODE_WRITE) begin
          if (left_r > CLW'(1)) begin
            left_nxt = left_r - CLW'(1);
            res[0]   = mk_word(in_data.data_byte, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
            n        = 3'd1;
          end else begin
            // Last byte of the chunk: release and program
            left_nxt = '0;
            res[0]   = mk_word(in_data.data_byte, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
            n        = 3'd1;
            if (rem_r != 16'd0) begin
              open    = 1'b1;
              open_at = 1'b1;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
      end
      CMD_START_RD: begin
        if (mode_r == MODE_IDLE) begin
          addr_nxt = in_data.address;
          rem_nxt  = in_data.length;
          res[0]   = mk_word(rd_op_r, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
          res[1]   = mk_word(in_data.address[15:8], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
          // Empty read: header alone, released after the low address byte
          res[2]   = mk_word(in_data.address[7:0], 1'b0, (in_data.length == 16'd0),
                             1'b0, 8'h00, 1'b0);
          n        = 3'd3;
          if (in_data.length != 16'd0) mode_nxt = MODE_READ;
        end
      end
      default: begin
        if (mode_r == MODE_READ) begin
          rem_nxt = rem_r - 16'd1;
          res[0]  = mk_word(DUMMY_BYTE, 1'b0, (rem_r == 16'd1), 1'b0,
                            in_data.bus_byte, 1'b1);
          n       = 3'd1;
          if (rem_r == 16'd1) mode_nxt = MODE_IDLE;
        end
      end
    endcase

    // Chunk runs to the next page boundary or the end of the request
    room  = CLW'(PAGE_BYTES) - CLW'(src_addr[LG-1:0]);
    chunk = (src_rem < 16'(room)) ? src_rem[CLW-1:0] : room;

    if (open) begin
      addr_nxt = src_addr + 16'(chunk);
      rem_nxt  = src_rem - 16'(chunk);
      left_nxt = chunk;
      if (open_at) begin
        res[1] = mk_word(we_op_r, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        res[2] = mk_word(wr_op_r, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        res[3] = mk_word(src_addr[15:8], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        res[4] = mk_word(src_addr[7:0], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        n      = 3'd5;
      end else begin
        res[0] = mk_word(we_op_r, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        res[1] = mk_word(wr_op_r, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        res[2] = mk_word(src_addr[15:8], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        res[3] = mk_word(src_addr[7:0], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        n      = 3'd4;
      end
    end

    for (int i = 0; i < MAX_WORDS; i++) begin
      if (n != 3'd0 && 3'(i) == n - 3'd1) res[i].last = 1'b1;
    end
  end

  // Queue load on a new request, shift on each word taken
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < MAX_WORDS; i++) ent_nxt[i] = ent_r[i];
    if (in_fire) begin
      cnt_nxt = n;
      for (int i = 0; i < MAX_WORDS; i++) ent_nxt[i] = res[i];
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 3'd1;
      for (int i = 0; i < MAX_WORDS - 1; i++) ent_nxt[i] = ent_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      addr_r <= '0;
      rem_r  <= '0;
      left_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        mode_r <= mode_nxt;
        addr_r <= addr_nxt;
        rem_r  <= rem_nxt;
        left_r <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WORDS; i++) ent_r[i] <= ent_nxt[i];
  end

endmodule

// ----- src/spiee_checker.sv -----
module spiee_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input spiee_pkg::out_word_t out_data
);
  import spiee_pkg::*;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // Reset empties the output queue
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Input is only taken while output waits if the final word of a request leaves now
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_ready && out_data.last)
    else $error("input taken with request words still queued");

  // A request's words follow one another without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside a request's words");

  // Read slots shift out the dummy byte
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> out_data.spi_byte == DUMMY_BYTE)
    else $error("read slot without dummy byte");

endmodule

bind spi_eeprom_page_write_sequencer spiee_checker u_spiee_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
